// ===== design/glff_pkg.sv =====
// Shared types and constants for the grid line trace and flood fill block.
package glff_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LINE  = 2'd1,
        OP_FILL  = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    localparam logic [1:0] MARK_EMPTY  = 2'd0;
    localparam logic [1:0] MARK_BORDER = 2'd1;
    localparam logic [1:0] MARK_SOLID  = 2'd2;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;
    localparam int ADDR_W = ROW_W + COL_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LINE_MAP,
        ST_LINE_SETUP,
        ST_LINE_STEP,
        ST_FILL_POP,
        ST_FILL_CHK,
        ST_FILL_NB_RD,
        ST_FILL_NB_CHK,
        ST_READ_WAIT,
        ST_OUT
    } t_state;

endpackage

// ===== design/glff_grid_mem.sv =====
// Grid cell memory: one write port and one read port with registered read data.
module glff_grid_mem
    import glff_pkg::*;
#(
    parameter int DEPTH = 2048
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [1:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [1:0]        o_rdata
);
    logic [1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/glff_stack_mem.sv =====
// Fill stack memory: one write port and one read port with registered read data.
module glff_stack_mem
    import glff_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [ADDR_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [ADDR_W-1:0] o_rdata
);
    logic [ADDR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/grid_line_trace_flood_fill_core.sv =====
// Top level of the grid line trace and flood fill block.
// Cells live in a 2048 x 2-bit memory addressed by {row, column}, the fill stack in a
// STACK_DEPTH x 11-bit memory. One command is taken at a time. A clear sweeps the whole
// cell memory. After reset the cell memory is swept to empty, during which no command
// is taken. A line maps its end points to cells, sets up, then traces cell by cell. A
// fill is bound by the registered memory reads: each pop reads the stack, then the
// popped cell, then each neighbor on the grid in turn. A stale stack entry is popped
// and dropped.
module grid_line_trace_flood_fill_core
    import glff_pkg::*;
#(
    parameter int GRID_ROWS   = 24,
    parameter int GRID_COLS   = 40,
    parameter int STACK_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], x_start[9:2], y_start[16:10], x_end[24:17], y_end[31:25],
    // cell_row[36:32], cell_col[42:37]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_value[1:0]
    output logic [7:0]  m_axis_tdata
);
    localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW  = SAW + 1;
    localparam int MEMD = 1 << ADDR_W;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic r_init, n_init;
    // Line registers (cells, signed to cover walking off either side).
    logic signed [7:0] r_c, n_c, r_r, n_r, r_c2, n_c2, r_r2, n_r2;
    logic signed [7:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [9:0] r_err, n_err;
    logic signed [8:0] r_xs, r_xe;
    logic signed [6:0] r_ys, r_ye;
    logic signed [8:0] n_xs, n_xe;
    logic signed [6:0] n_ys, n_ye;
    logic [SPW-1:0] r_sp, n_sp;
    logic [ROW_W-1:0] r_fr, n_fr, r_nr, n_nr;
    logic [COL_W-1:0] r_fc, n_fc, r_nc, n_nc;
    logic [1:0] r_nb, n_nb;
    logic r_chk, n_chk;
    logic [1:0] r_val, n_val;
    logic r_ovalid, n_ovalid;

    logic              g_we;
    logic [ADDR_W-1:0] g_waddr, g_raddr;
    logic [1:0]        g_wdata, g_rdata;
    logic              s_we;
    logic [SAW-1:0]    s_waddr, s_raddr;
    logic [ADDR_W-1:0] s_wdata, s_rdata;

    glff_grid_mem #(.DEPTH(MEMD)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata)
    );
    glff_stack_mem #(.DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    t_opcode in_op;
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    assign in_op  = t_opcode'(s_axis_tdata[1:0]);
    assign in_row = s_axis_tdata[36:32];
    assign in_col = s_axis_tdata[42:37];

    assign s_axis_tready = (r_state == ST_IDLE) && !r_init;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_val};

    function automatic logic signed [7:0] col_map(input logic signed [8:0] wx);
        logic [15:0] p;
        begin
            p = 16'(unsigned'(9'(wx + 9'sd128))) * 16'(GRID_COLS);
            col_map = 8'(p >> 8);
        end
    endfunction

    function automatic logic signed [7:0] row_map(input logic signed [6:0] wy);
        logic signed [7:0] y;
        logic [12:0] p;
        logic [12:0] q;
        begin
            y = 8'(wy);
            if (y > 8'sd50) y = 8'sd50;
            if (y < -8'sd50) y = -8'sd50;
            p = 13'(unsigned'(8'(8'sd50 - y))) * 13'(GRID_ROWS - 1);
            // Divide by 100 via reciprocal: p <= 3100; 1311/2^17 with one correction.
            q = 13'((32'(p) * 32'd1311) >> 17);
            if (p - 13'(q * 13'd100) >= 13'd100) q = q + 13'd1;
            row_map = 8'(q);
        end
    endfunction

    logic signed [10:0] e2;
    logic in_g_line;
    assign e2 = 11'(r_err) <<< 1;
    assign in_g_line = (r_r >= 0) && (r_r < GRID_ROWS) && (r_c >= 0) && (r_c < GRID_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sweep <= '0;
            r_init <= 1'b1;
            r_sp <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_init <= n_init;
            r_sp <= n_sp;
            r_ovalid <= n_ovalid;
        end
        r_c <= n_c; r_r <= n_r; r_c2 <= n_c2; r_r2 <= n_r2;
        r_dx <= n_dx; r_dy <= n_dy; r_err <= n_err;
        r_xs <= n_xs; r_xe <= n_xe; r_ys <= n_ys; r_ye <= n_ye;
        r_fr <= n_fr; r_fc <= n_fc; r_nr <= n_nr; r_nc <= n_nc;
        r_nb <= n_nb; r_chk <= n_chk; r_val <= n_val;
    end

    always_comb begin
        n_state = r_state; n_sweep = r_sweep; n_init = r_init;
        n_c = r_c; n_r = r_r; n_c2 = r_c2; n_r2 = r_r2; n_dx = r_dx; n_dy = r_dy;
        n_err = r_err; n_xs = r_xs; n_xe = r_xe; n_ys = r_ys; n_ye = r_ye;
        n_sp = r_sp; n_fr = r_fr; n_fc = r_fc; n_nr = r_nr; n_nc = r_nc; n_nb = r_nb;
        n_chk = r_chk; n_val = r_val; n_ovalid = r_ovalid;
        g_we = 1'b0; g_waddr = r_sweep; g_wdata = MARK_EMPTY; g_raddr = {r_fr, r_fc};
        s_we = 1'b0; s_waddr = r_sp[SAW-1:0]; s_wdata = {r_nr, r_nc};
        s_raddr = SAW'(r_sp - SPW'(1));
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        if (r_init) begin
            g_we = 1'b1; g_waddr = r_sweep; g_wdata = MARK_EMPTY;
            n_sweep = r_sweep + 1'b1;
            if (&r_sweep) n_init = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    unique case (in_op)
                        OP_CLEAR: begin
                            n_sweep = '0;
                            n_state = ST_CLEAR;
                        end
                        OP_LINE: begin
                            n_xs = 9'(signed'(s_axis_tdata[9:2]));
                            n_ys = s_axis_tdata[16:10];
                            n_xe = 9'(signed'(s_axis_tdata[24:17]));
                            n_ye = s_axis_tdata[31:25];
                            n_state = ST_LINE_MAP;
                        end
                        OP_FILL: begin
                            if (32'(in_row) < GRID_ROWS && 32'(in_col) < GRID_COLS) begin
                                s_we = 1'b1; s_waddr = '0; s_wdata = {in_row, in_col};
                                n_sp = SPW'(1);
                                n_state = ST_FILL_POP;
                            end
                        end
                        OP_READ: begin
                            n_fr = in_row; n_fc = in_col;
                            n_state = ST_READ_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                g_we = 1'b1; g_waddr = r_sweep; g_wdata = MARK_SOLID;
                n_sweep = r_sweep + 1'b1;
                if (&r_sweep) n_state = ST_IDLE;
            end
            ST_LINE_MAP: begin
                n_c = col_map(r_xs); n_r = row_map(r_ys);
                n_c2 = col_map(r_xe); n_r2 = row_map(r_ye);
                n_state = ST_LINE_SETUP;
            end
            ST_LINE_SETUP: begin
                n_dx = (r_c2 > r_c) ? r_c2 - r_c : r_c - r_c2;
                n_dy = (r_r2 > r_r) ? r_r2 - r_r : r_r - r_r2;
                n_err = 10'(n_dx) - 10'(n_dy);
                n_state = ST_LINE_STEP;
            end
            ST_LINE_STEP: begin
                if (in_g_line) begin
                    g_we = 1'b1;
                    g_waddr = {ROW_W'(r_r), COL_W'(r_c)};
                    g_wdata = MARK_BORDER;
                end
                if (r_c == r_c2 && r_r == r_r2) begin
                    n_state = ST_IDLE;
                end else begin
                    n_err = r_err;
                    if (e2 > -11'(r_dy)) begin
                        n_err = n_err - 10'(r_dy);
                        n_c = (r_c < r_c2) ? r_c + 8'sd1 : r_c - 8'sd1;
                    end
                    if (e2 < 11'(r_dx)) begin
                        n_err = n_err + 10'(r_dx);
                        n_r = (r_r < r_r2) ? r_r + 8'sd1 : r_r - 8'sd1;
                    end
                end
            end
            ST_FILL_POP: begin
                if (r_sp == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    // Stack read issued now; data arrives next cycle.
                    n_sp = r_sp - SPW'(1);
                    n_state = ST_FILL_CHK;
                end
            end
            ST_FILL_CHK: begin
                // Stack data valid, issue grid read.
                n_fr = s_rdata[ADDR_W-1:COL_W];
                n_fc = s_rdata[COL_W-1:0];
                g_raddr = s_rdata;
                n_nb = 2'd0;
                n_state = ST_FILL_NB_RD;
                n_chk = 1'b1;
            end
            ST_FILL_NB_RD: begin
                if (r_chk) begin
                    // Grid data of popped cell is valid.
                    if (32'(r_fr) < GRID_ROWS && 32'(r_fc) < GRID_COLS
                        && g_rdata == MARK_SOLID) begin
                        g_we = 1'b1; g_waddr = {r_fr, r_fc}; g_wdata = MARK_EMPTY;
                        n_chk = 1'b0;
                        n_nb = 2'd0;
                        n_state = ST_FILL_NB_RD;
                    end else begin
                        n_state = ST_FILL_POP;
                    end
                end else begin
                    // Pick neighbor r_nb if it exists, issue its read.
                    logic ok;
                    ok = 1'b0;
                    n_nr = r_fr; n_nc = r_fc;
                    case (r_nb)
                        2'd0: begin ok = (r_fr > 0); n_nr = r_fr - 1'b1; end
                        2'd1: begin ok = (32'(r_fr) < GRID_ROWS - 1); n_nr = r_fr + 1'b1; end
                        2'd2: begin ok = (r_fc > 0); n_nc = r_fc - 1'b1; end
                        default: begin ok = (32'(r_fc) < GRID_COLS - 1); n_nc = r_fc + 1'b1; end
                    endcase
                    g_raddr = {n_nr, n_nc};
                    if (ok) begin
                        n_state = ST_FILL_NB_CHK;
                    end else if (r_nb == 2'd3) begin
                        n_state = ST_FILL_POP;
                    end else begin
                        n_nb = r_nb + 1'b1;
                    end
                end
            end
            ST_FILL_NB_CHK: begin
                if (g_rdata == MARK_SOLID && 32'(r_sp) < STACK_DEPTH) begin
                    s_we = 1'b1; s_waddr = r_sp[SAW-1:0]; s_wdata = {r_nr, r_nc};
                    n_sp = r_sp + SPW'(1);
                end
                if (r_nb == 2'd3) begin
                    n_state = ST_FILL_POP;
                end else begin
                    n_nb = r_nb + 1'b1;
                    n_state = ST_FILL_NB_RD;
                end
            end
            ST_READ_WAIT: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid) begin
                    n_val = (32'(r_fr) < GRID_ROWS && 32'(r_fc) < GRID_COLS)
                            ? g_rdata : MARK_EMPTY;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
